### src/laq_pkg.sv
`timescale 1ns / 1ps

package laq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int SLOT_W    = 6;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 40;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DELETE  = 2'd1,
        REQ_DISPLAY = 2'd2,
        REQ_UPDATE  = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    ins;        // write item at the next rear slot, advance the rear pointer
        logic    upd;        // write item at slot_index
        logic    del;        // read front slot, advance or clear pointers
        logic    disp;       // read front slot, start the display walk
        logic    next;       // read the following slot of the display walk
        logic    out_load;   // load the output register
        logic    out_ram;    // output value from slot read data, else zero
        logic    out_last;
        status_t out_status;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic full;          // rear pointer at the last slot, queue not empty
        logic upd_hit;       // slot_index lies between front and rear
        logic at_rear;       // display walk sits on the rear slot
        logic out_free;      // output register free at this edge
    } stat_t;

endpackage

### src/laq_ram.sv
`timescale 1ns / 1ps

module laq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/laq_ctrl.sv
`timescale 1ns / 1ps

module laq_ctrl
    import laq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  req_t  req,
    input  stat_t stat,
    output logic  s_tready,
    output cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } state_t;

    state_t state_reg, state_next;
    logic   is_del_reg, is_del_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd            = '0;
        cmd.out_status = ST_OK;
        state_next     = state_reg;
        is_del_next    = is_del_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (req)
                        REQ_INSERT: begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                            if (stat.full) begin
                                cmd.out_status = ST_OVERFLOW;
                            end else begin
                                cmd.ins = 1'b1;
                            end
                        end
                        REQ_UPDATE: begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                            if (stat.upd_hit) begin
                                cmd.upd = 1'b1;
                            end else begin
                                cmd.out_status = ST_NOTFOUND;
                            end
                        end
                        REQ_DELETE, REQ_DISPLAY: begin
                            if (stat.empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.del     = (req == REQ_DELETE);
                                cmd.disp    = (req == REQ_DISPLAY);
                                is_del_next = (req == REQ_DELETE);
                                state_next  = S_STREAM;
                            end
                        end
                    endcase
                end
            end
            S_STREAM: begin
                // hold the read data until the output register frees up
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_ram  = 1'b1;
                    cmd.out_last = is_del_reg || stat.at_rear;
                    if (is_del_reg || stat.at_rear) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.next = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            is_del_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            is_del_reg <= is_del_next;
        end
    end

endmodule

### src/laq_dp.sv
`timescale 1ns / 1ps

module laq_dp
    import laq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cmd_t                     cmd,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic [SLOT_W-1:0]        slot_index,
    input  logic                     m_tready,
    output stat_t                    stat,
    output logic                     m_tvalid,
    output logic signed [DATA_W-1:0] m_tdata,
    output status_t                  m_tuser,
    output logic                     m_tlast
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [PTR_W-1:0] front_reg, front_next;
    logic [PTR_W-1:0] rear_reg, rear_next;
    logic             empty_reg, empty_next;
    logic [PTR_W-1:0] walk_reg, walk_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic signed [DATA_W-1:0] m_tdata_reg, m_tdata_next;
    status_t                  m_tuser_reg, m_tuser_next;
    logic                     m_tlast_reg, m_tlast_next;

    logic                     wr_en, rd_en;
    logic [PTR_W-1:0]         wr_addr, rd_addr, ins_addr;
    logic signed [DATA_W-1:0] rd_data;

    assign stat.empty    = empty_reg;
    assign stat.full     = !empty_reg && (rear_reg == PTR_W'(DEPTH - 1));
    assign stat.upd_hit  = !empty_reg && (slot_index >= SLOT_W'(front_reg))
                           && (slot_index <= SLOT_W'(rear_reg));
    assign stat.at_rear  = (walk_reg == rear_reg);
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // an empty queue restarts at slot zero
    assign ins_addr = empty_reg ? '0 : rear_reg + PTR_W'(1);
    assign wr_en    = cmd.ins || cmd.upd;
    assign wr_addr  = cmd.upd ? slot_index[PTR_W-1:0] : ins_addr;
    assign rd_en    = cmd.del || cmd.disp || cmd.next;
    assign rd_addr  = cmd.next ? walk_reg + PTR_W'(1) : front_reg;

    laq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        front_next = front_reg;
        rear_next  = rear_reg;
        empty_next = empty_reg;
        walk_next  = walk_reg;
        if (cmd.ins) begin
            rear_next  = ins_addr;
            empty_next = 1'b0;
            if (empty_reg) begin
                front_next = '0;
            end
        end
        if (cmd.del) begin
            // drop the last entry: both pointers return to slot zero
            if (front_reg >= rear_reg) begin
                front_next = '0;
                rear_next  = '0;
                empty_next = 1'b1;
            end else begin
                front_next = front_reg + PTR_W'(1);
            end
        end
        if (cmd.disp) begin
            walk_next = front_reg;
        end else if (cmd.next) begin
            walk_next = walk_reg + PTR_W'(1);
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = cmd.out_ram ? rd_data : '0;
            m_tuser_next  = cmd.out_status;
            m_tlast_next  = cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg    <= '0;
            rear_reg     <= '0;
            empty_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            front_reg    <= front_next;
            rear_reg     <= rear_next;
            empty_reg    <= empty_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg    <= walk_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### src/linear_array_queue_core.sv
`timescale 1ns / 1ps

// Linear array queue of DEPTH signed 32-bit entries held in a single-port-read
// slot RAM with registered read data. Insert, update, and any request on an
// empty queue complete when accepted: the item is accepted and its result is
// loaded into the output register at the same edge. Delete first reads the
// front slot and then presents it. Display first reads the front slot, then
// streams one entry per cycle while m_tready stays high. The next item is taken
// once the previous request's final result sits in the output register and
// that register is free; a stalled output holds off s_tready. Inserts report
// overflow once the rear pointer reaches the last slot, until deletes empty the
// queue and both pointers return to slot zero.
module linear_array_queue_core
    import laq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] item_value, [37:32] slot_index
    input  logic [REQ_W-1:0]     s_tuser,   // [1:0] req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // [31:0] out_value
    output logic [STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic                 m_tlast
);

    cmd_t                     cmd;
    stat_t                    stat;
    logic signed [DATA_W-1:0] item_value;
    logic [SLOT_W-1:0]        slot_index;
    logic signed [DATA_W-1:0] out_value;
    status_t                  out_status;

    assign item_value = s_tdata[DATA_W-1:0];
    assign slot_index = s_tdata[DATA_W+SLOT_W-1:DATA_W];

    laq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req      (req_t'(s_tuser)),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    laq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .item_value (item_value),
        .slot_index (slot_index),
        .m_tready   (m_tready),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tdata    (out_value),
        .m_tuser    (out_status),
        .m_tlast    (m_tlast)
    );

    assign m_tdata = out_value;
    assign m_tuser = out_status;

    // never take an item while a result is stuck in the output register
    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("item accepted while output register blocked");

    // an insert always leaves the queue holding something
    a_insert_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == REQ_INSERT) |=> !stat.empty)
        else $error("queue empty after insert");

    // a delete or display on a filled queue holds off the next item
    a_stream_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !stat.empty
         && (s_tuser == REQ_DELETE || s_tuser == REQ_DISPLAY)) |=> !s_tready)
        else $error("item taken during slot read");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import laq_pkg::*;

    localparam int N             = DEPTH_DEF;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] value;
        logic              last;
    } result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]     s_tuser  = REQ_INSERT;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;

    // mirror of the queue contents, updated as each item is accepted
    logic [DATA_W-1:0] slot_mem [N];
    logic [SLOT_W-1:0] head_ptr    = '0;
    logic [SLOT_W-1:0] tail_ptr    = '0;
    logic              queue_empty = 1'b1;
    result_t           expected_results[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int cycle_count   = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    linear_array_queue_core #(
        .DEPTH(N)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic void push_result(status_t st, logic [DATA_W-1:0] v, logic l);
        result_t r;
        r.status = st;
        r.value  = v;
        r.last   = l;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_request(req_t req, logic [DATA_W-1:0] val,
                                            logic [SLOT_W-1:0] idx);
        int i;
        case (req)
            REQ_INSERT: begin
                if (!queue_empty && int'(tail_ptr) == N - 1) begin
                    push_result(ST_OVERFLOW, '0, 1'b1);
                end else begin
                    if (queue_empty) begin
                        head_ptr    = '0;
                        tail_ptr    = '0;
                        queue_empty = 1'b0;
                    end else begin
                        tail_ptr = tail_ptr + SLOT_W'(1);
                    end
                    slot_mem[tail_ptr] = val;
                    push_result(ST_OK, '0, 1'b1);
                end
            end
            REQ_DELETE: begin
                if (queue_empty) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    push_result(ST_OK, slot_mem[head_ptr], 1'b1);
                    // removing the only entry rewinds both pointers
                    if (head_ptr >= tail_ptr) begin
                        head_ptr    = '0;
                        tail_ptr    = '0;
                        queue_empty = 1'b1;
                    end else begin
                        head_ptr = head_ptr + SLOT_W'(1);
                    end
                end
            end
            REQ_DISPLAY: begin
                if (queue_empty) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (i = int'(head_ptr); i <= int'(tail_ptr); i++) begin
                        push_result(ST_OK, slot_mem[i], i == int'(tail_ptr));
                    end
                end
            end
            default: begin
                if (!queue_empty && idx >= head_ptr && idx <= tail_ptr) begin
                    slot_mem[idx] = val;
                    push_result(ST_OK, '0, 1'b1);
                end else begin
                    push_result(ST_NOTFOUND, '0, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic void note_mismatch(result_t exp_r, logic have_exp);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            if (have_exp)
                $display("mismatch %0d: exp st %0d val %h last %b, got st %0d val %h last %b",
                         results_seen, exp_r.status, exp_r.value, exp_r.last,
                         m_tuser, m_tdata, m_tlast);
            else
                $display("unexpected result %0d: status %0d value %h last %b",
                         results_seen, m_tuser, m_tdata, m_tlast);
        end
    endfunction

    always @(posedge aclk) begin : check_results
        result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                exp_r = '0;
                note_mismatch(exp_r, 1'b0);
            end else begin
                exp_r = expected_results.pop_front();
                status_seen[exp_r.status]++;
                if (m_tuser !== exp_r.status || m_tdata !== exp_r.value ||
                    m_tlast !== exp_r.last)
                    note_mismatch(exp_r, 1'b1);
            end
        end
    end

    task automatic send_request(req_t req, logic [DATA_W-1:0] val, logic [SLOT_W-1:0] idx);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            // drop valid and put junk on the bus while idle
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= {2'b00, 6'($urandom()), 32'($urandom())};
            s_tuser  <= 2'($urandom());
            while ($urandom_range(0, 99) < send_idle_pct) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx, val};
        s_tuser  <= req;
        do @(posedge aclk); while (!s_tready);
        predict_request(req, val, idx);
        items_sent++;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    task automatic test_empty_queue();
        send_request(REQ_DISPLAY, 32'h1234_5678, 6'd0);
        send_request(REQ_DELETE, 32'h0, 6'd0);
        send_request(REQ_UPDATE, 32'hdead_beef, 6'd0);
        send_request(REQ_UPDATE, 32'hffff_ffff, 6'd63);
    endtask

    task automatic test_value_extremes();
        send_request(REQ_INSERT, 32'h8000_0000, 6'd63);
        send_request(REQ_INSERT, 32'h7fff_ffff, 6'd0);
        send_request(REQ_INSERT, 32'h0000_0000, 6'd21);
        send_request(REQ_INSERT, 32'hffff_ffff, 6'd42);
        send_request(REQ_DISPLAY, 32'h0, 6'd0);
        send_request(REQ_UPDATE, 32'h5555_5555, 6'd0);
        send_request(REQ_UPDATE, 32'haaaa_aaaa, 6'd3);
        send_request(REQ_UPDATE, 32'h0000_0001, 6'd4);
        send_request(REQ_DELETE, 32'h0, 6'd0);
        send_request(REQ_UPDATE, 32'h0000_0002, 6'd0);
        send_request(REQ_DISPLAY, 32'h0, 6'd0);
        send_request(REQ_DELETE, 32'h0, 6'd0);
        send_request(REQ_DELETE, 32'h0, 6'd0);
        send_request(REQ_DELETE, 32'h0, 6'd0);
        send_request(REQ_DISPLAY, 32'h0, 6'd0);
        send_request(REQ_DELETE, 32'h0, 6'd0);
        send_request(REQ_INSERT, 32'h0000_0063, 6'd0);
    endtask

    // fill to the last slot, then show that freed front slots are not reused
    task automatic test_overflow_after_deletes();
        while (!queue_empty) send_request(REQ_DELETE, pick_value(), 6'($urandom()));
        repeat (N) send_request(REQ_INSERT, pick_value(), 6'($urandom()));
        send_request(REQ_INSERT, pick_value(), 6'($urandom()));
        repeat (3) send_request(REQ_DELETE, pick_value(), 6'($urandom()));
        send_request(REQ_INSERT, pick_value(), 6'($urandom()));
        send_request(REQ_UPDATE, pick_value(), 6'(N - 1));
        send_request(REQ_UPDATE, pick_value(), 6'd0);
        send_request(REQ_UPDATE, pick_value(), head_ptr);
        send_request(REQ_DISPLAY, pick_value(), 6'($urandom()));
        while (!queue_empty) send_request(REQ_DELETE, pick_value(), 6'($urandom()));
        send_request(REQ_INSERT, pick_value(), 6'($urandom()));
        send_request(REQ_UPDATE, pick_value(), 6'd1);
        send_request(REQ_DISPLAY, pick_value(), 6'($urandom()));
        send_request(REQ_DELETE, pick_value(), 6'($urandom()));
    endtask

    task automatic test_random_traffic(int n_items);
        int                k;
        int                pick;
        int                ins_w;
        int                del_w;
        req_t              req;
        logic [SLOT_W-1:0] idx;
        for (k = 0; k < n_items; k++) begin
            // switch between filling, draining and mixed bursts
            if (k % 16 == 0) begin
                case ($urandom_range(0, 2))
                    0:       begin ins_w = 70; del_w = 10; end
                    1:       begin ins_w = 20; del_w = 60; end
                    default: begin ins_w = 40; del_w = 30; end
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < ins_w)
                req = REQ_INSERT;
            else if (pick < ins_w + del_w)
                req = REQ_DELETE;
            else if (pick < ins_w + del_w + 8)
                req = REQ_DISPLAY;
            else
                req = REQ_UPDATE;
            if (!queue_empty && $urandom_range(0, 3) != 0)
                idx = SLOT_W'($urandom_range(int'(head_ptr), int'(tail_ptr)));
            else
                idx = 6'($urandom());
            send_request(req, pick_value(), idx);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_idling(0, 0);
        test_empty_queue();
        test_value_extremes();
        test_random_traffic(70);

        set_idling(87, 0);
        test_random_traffic(75);

        set_idling(0, 87);
        test_random_traffic(75);

        set_idling(30, 30);
        test_overflow_after_deletes();
        test_random_traffic(50);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d requests under four idle/stall mixes; checked %0d results",
                 items_sent, results_seen);
        $display("  ok %0d, overflow %0d, empty/underflow %0d, not-found %0d, mismatches %0d",
                 status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_EMPTY],
                 status_seen[ST_NOTFOUND], mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
